### rtl/core/flc_pkg.sv
// Shared types and constants for the full linear convolution block.
// No dependencies; used by full_linear_convolution_top.
`timescale 1ns / 1ps
`default_nettype none

package flc_pkg;

    localparam int MAX_TAPS_DEF    = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int OUT_BITS        = 38;
    localparam int TAP_IDX_W       = 6;
    localparam int TAP_CNT_W       = 7;
    localparam int OUT_TDATA_W     = ((OUT_BITS + 7) / 8) * 8;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

### rtl/core/full_linear_convolution_top.sv
// Full linear convolution of a streamed trace with a stored filter.
// Depends on flc_pkg for constants and the sequencer state type.
//
// Taps are loaded one at a time (tuser high) into a tap memory, trace samples
// (tuser low) go into a circular delay-line memory. Each sample yields one output; the
// sample marked tlast also yields n-1 tail outputs, n being tap_count held to 1..MAX_TAPS,
// the final one marked tlast, after which the delay line reads as zero again. One
// multiply-accumulate walks the two memories one tap per cycle; each product passes the
// registered memory read, the product register and the accumulator, and the sum is
// emitted once these have drained and the output register is free. A tap load only
// writes the tap memory, with no walk. Input is taken only between outputs; a finished
// output waits in an output register without blocking the next input. Emptying the delay
// line is done with per-entry valid flags, so there is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module full_linear_convolution_top #(
    parameter int MAX_TAPS    = flc_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = flc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // configuration: tap_count
    input  wire logic                                   i_cfg_we,
    input  wire logic [flc_pkg::TAP_CNT_W-1:0]          i_cfg_wdata,
    // input items
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // tdata: tap_index[5:0], sample_value, zero pad
    input  wire logic [((flc_pkg::TAP_IDX_W + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: command
    input  wire logic                                   s_axis_tuser,
    input  wire logic                                   s_axis_tlast,
    // result items
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // tdata: out_value, zero pad
    output logic [flc_pkg::OUT_TDATA_W-1:0]             m_axis_tdata,
    output logic                                        m_axis_tlast
);

    localparam int AW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int KW  = $clog2(MAX_TAPS + 1);
    localparam int PW  = 2 * SAMPLE_BITS;
    localparam int OB  = flc_pkg::OUT_BITS;
    localparam int TIW = flc_pkg::TAP_IDX_W;

    // memories
    logic [SAMPLE_BITS-1:0] r_tap_mem [2**AW];
    logic [SAMPLE_BITS-1:0] r_dl_mem  [MAX_TAPS];
    logic [MAX_TAPS-1:0]    r_valid;

    // control
    flc_pkg::t_state        r_state, n_state;
    logic [flc_pkg::TAP_CNT_W-1:0] r_tap_count;
    logic [AW-1:0]          r_wp;
    logic [AW-1:0]          r_rd_addr;
    logic [KW-1:0]          r_k;
    logic [KW-1:0]          r_n;
    logic [KW-1:0]          r_tail;
    logic                   r_last;
    logic                   r_v1, r_v2;
    logic                   r_out_valid;

    // datapath
    logic [SAMPLE_BITS-1:0] r_tap_q, r_dl_q;
    logic                   r_vld_q;
    logic signed [PW-1:0]   r_prod;
    logic [OB-1:0]          r_acc;
    logic [OB-1:0]          r_out_value;
    logic                   r_out_last;

    // decoded fields
    logic                   w_cmd;
    logic [TIW-1:0]         w_tap_index;
    logic [SAMPLE_BITS-1:0] w_sample;

    // strobes
    logic                   w_accept;
    logic                   w_load;
    logic                   w_push;
    logic                   w_issue;
    logic                   w_emit;
    logic                   w_shift0;
    logic                   w_clear;
    logic                   w_out_free;

    logic [KW-1:0]          w_n_sat;
    logic [AW-1:0]          w_wp_next;
    logic [AW-1:0]          w_rd_prev;
    logic [SAMPLE_BITS-1:0] w_dl_op;
    logic signed [PW-1:0]   w_prod;
    logic [OB+PW-1:0]       w_prod_ext;

    assign w_cmd       = s_axis_tuser;
    assign w_tap_index = s_axis_tdata[TIW-1:0];
    assign w_sample    = s_axis_tdata[TIW+SAMPLE_BITS-1:TIW];

    assign s_axis_tready = (r_state == flc_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load        = w_accept && (w_cmd == flc_pkg::CMD_LOAD);
    assign w_push        = w_accept && (w_cmd == flc_pkg::CMD_SAMPLE);
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign w_n_sat = (r_tap_count == '0) ? KW'(1) :
                     (r_tap_count > flc_pkg::TAP_CNT_W'(MAX_TAPS)) ? KW'(MAX_TAPS) :
                     r_tap_count[KW-1:0];

    assign w_wp_next = (r_wp == AW'(MAX_TAPS - 1)) ? '0 : r_wp + 1'b1;
    assign w_rd_prev = (r_rd_addr == '0) ? AW'(MAX_TAPS - 1) : r_rd_addr - 1'b1;

    assign w_dl_op    = r_vld_q ? r_dl_q : '0;
    assign w_prod     = $signed(r_tap_q) * $signed(w_dl_op);
    assign w_prod_ext = {{OB{r_prod[PW-1]}}, r_prod};

    // sequencer
    always_comb begin
        n_state  = r_state;
        w_issue  = 1'b0;
        w_emit   = 1'b0;
        w_shift0 = 1'b0;
        w_clear  = 1'b0;
        unique case (r_state)
            flc_pkg::ST_IDLE: begin
                if (w_push) begin
                    n_state = flc_pkg::ST_MAC;
                end
            end
            flc_pkg::ST_MAC: begin
                w_issue = (r_k != r_n);
                if (r_k == r_n && !r_v1 && !r_v2) begin
                    n_state = flc_pkg::ST_EMIT;
                end
            end
            flc_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    if (r_tail != '0) begin
                        w_shift0 = 1'b1;
                        n_state  = flc_pkg::ST_MAC;
                    end else begin
                        w_clear = r_last;
                        n_state = flc_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = flc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= flc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // memories: write, registered read
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_tap_mem[w_tap_index[AW-1:0]] <= w_sample;
        end
        if (w_push) begin
            r_dl_mem[w_wp_next] <= w_sample;
        end
        if (w_issue) begin
            r_tap_q <= r_tap_mem[r_k[AW-1:0]];
            r_dl_q  <= r_dl_mem[r_rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= flc_pkg::TAP_CNT_W'(1);
            r_valid     <= '0;
            r_wp        <= '0;
            r_rd_addr   <= '0;
            r_k         <= '0;
            r_n         <= KW'(1);
            r_tail      <= '0;
            r_last      <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
            r_vld_q     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tap_count <= i_cfg_wdata;
            end
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            if (w_issue) begin
                r_vld_q   <= r_valid[r_rd_addr];
                r_k       <= r_k + 1'b1;
                r_rd_addr <= w_rd_prev;
            end
            if (w_push) begin
                r_wp               <= w_wp_next;
                r_rd_addr          <= w_wp_next;
                r_valid[w_wp_next] <= 1'b1;
                r_k                <= '0;
                r_n                <= w_n_sat;
                r_tail             <= s_axis_tlast ? w_n_sat - 1'b1 : '0;
                r_last             <= s_axis_tlast;
            end
            if (w_shift0) begin
                r_wp               <= w_wp_next;
                r_rd_addr          <= w_wp_next;
                r_valid[w_wp_next] <= 1'b0;
                r_k                <= '0;
                r_tail             <= r_tail - 1'b1;
            end
            if (w_clear) begin
                r_valid <= '0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // multiply-accumulate and output payload
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= w_prod;
        end
        if (w_push || w_shift0) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + w_prod_ext[OB-1:0];
        end
        if (w_emit) begin
            r_out_value <= r_acc;
            r_out_last  <= r_last && (r_tail == '0);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(flc_pkg::OUT_TDATA_W - OB){1'b0}}, r_out_value};
    assign m_axis_tlast  = r_out_last;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_last && r_tail == '0) |=> (r_valid == '0))
        else $error("delay line not emptied after final output");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != flc_pkg::ST_IDLE) |-> (r_k <= r_n && r_tail < r_n))
        else $error("tap walk or tail count out of range");

    a_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != flc_pkg::ST_MAC) |-> (!r_v1 && !r_v2))
        else $error("accumulate pipeline busy outside tap walk");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !w_emit)
        else $error("output register overwritten while stalled");

endmodule

`default_nettype wire
